FILE: sv/osd_diw_pkg.sv
// Shared types, constants and codes for the decimal integer field writer.
package osd_diw_pkg;

    localparam int COLUMNS_PER_ROW = 30;
    localparam int MAX_DIGITS      = 10;
    // A 31-bit magnitude never needs more than ten decimal digits.
    localparam int NUM_CELLS       = 10;
    localparam int BITS_PER_CYCLE  = 2;
    localparam int CONV_CYCLES     = 32 / BITS_PER_CYCLE;
    localparam int CNT_W           = $clog2(CONV_CYCLES);

    localparam logic [7:0] CODE_ZERO  = 8'h0A;
    localparam logic [7:0] CODE_MINUS = 8'h49;
    localparam logic [7:0] CODE_BLANK = 8'h00;

    typedef logic [3:0] t_bcd;
    typedef logic [NUM_CELLS-1:0][3:0] t_digits;

    typedef struct packed {
        logic               req_type;
        logic        [3:0]  row;
        logic        [4:0]  start_column;
        logic        [3:0]  field_len;
        logic signed [31:0] value;
    } t_req;

    typedef struct packed {
        logic [8:0] display_addr;
        logic [7:0] char_code;
        logic       last;
    } t_wr;

    typedef struct packed {
        logic clear;
        logic conv;
        logic shift;
    } t_cell_ctrl;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONV,
        ST_PREP,
        ST_EMIT
    } t_state;

endpackage

FILE: sv/osd_diw_if.sv
// Valid/ready channel interfaces for requests and character-memory writes.
interface osd_diw_req_if;
    import osd_diw_pkg::*;
    logic valid;
    logic ready;
    t_req data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface osd_diw_wr_if;
    import osd_diw_pkg::*;
    logic valid;
    logic ready;
    t_wr  data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

FILE: sv/osd_diw_cell.sv
// One BCD digit cell: a clear, two shift-and-add-3 steps per cycle, or a shift towards digit 0.
module osd_diw_cell
    import osd_diw_pkg::*;
(
    input  logic       i_clk,
    input  t_cell_ctrl i_ctrl,
    input  logic [1:0] i_bits,
    input  t_bcd       i_upper,
    output t_bcd       o_digit,
    output logic [1:0] o_bits
);

    function automatic t_bcd adj(input t_bcd d);
        return (d >= 4'd5) ? t_bcd'(d + 4'd3) : d;
    endfunction

    t_bcd r_digit;
    t_bcd n_digit;
    t_bcd w_a1;
    t_bcd w_s1;
    t_bcd w_a2;
    t_bcd w_s2;

    // Bit 1 of i_bits is the earlier bit of the pair, bit 0 the later one.
    always_comb begin
        w_a1   = adj(r_digit);
        w_s1   = {w_a1[2:0], i_bits[1]};
        w_a2   = adj(w_s1);
        w_s2   = {w_a2[2:0], i_bits[0]};
        o_bits = {w_a1[3], w_a2[3]};
    end

    always_comb begin
        if (i_ctrl.clear) begin
            n_digit = '0;
        end else if (i_ctrl.conv) begin
            n_digit = w_s2;
        end else if (i_ctrl.shift) begin
            n_digit = i_upper;
        end else begin
            n_digit = r_digit;
        end
    end

    always_ff @(posedge i_clk) begin
        r_digit <= n_digit;
    end

    assign o_digit = r_digit;

endmodule

FILE: sv/osd_diw_chain.sv
// Row of digit cells; binary bits enter at digit 0 and carries pass upwards.
module osd_diw_chain
    import osd_diw_pkg::*;
(
    input  logic       i_clk,
    input  t_cell_ctrl i_ctrl,
    input  logic [1:0] i_bits,
    output t_digits    o_digits
);

    logic [NUM_CELLS:0][1:0] w_bits;
    t_bcd [NUM_CELLS:0]      w_upper;

    assign w_bits[0]          = i_bits;
    assign w_upper[NUM_CELLS] = '0;

    for (genvar g = 0; g < NUM_CELLS; g++) begin : g_cell
        osd_diw_cell u_cell (
            .i_clk   (i_clk),
            .i_ctrl  (i_ctrl),
            .i_bits  (w_bits[g]),
            .i_upper (w_upper[g+1]),
            .o_digit (o_digits[g]),
            .o_bits  (w_bits[g+1])
        );
        assign w_upper[g] = o_digits[g];
    end

endmodule

FILE: sv/osd_decimal_int_writer.sv
// Sequence: a request is taken in the idle state, converted by the digit cells
// (two bits per cycle), prepared in the PREP state, and its first write is registered in EMIT;
// then one write per cycle while the sink is ready.
// A new request is taken only in the idle state, after the last write has been loaded.
// Reset: synchronous, active low; clears the sequencer and the output valid flag.
module osd_decimal_int_writer
    import osd_diw_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    osd_diw_req_if.sink         i_req,
    osd_diw_wr_if.source        o_wr
);

    t_state           r_state;
    t_state           n_state;
    logic [31:0]      r_bin;
    logic [CNT_W-1:0] r_cnt;
    logic             r_blank;
    logic             r_neg;
    logic             r_zero;
    logic [3:0]       r_row;
    logic [4:0]       r_start;
    logic [3:0]       r_len;
    logic [3:0]       r_k;
    logic [3:0]       r_j;
    logic             r_out_valid;
    t_wr              r_out;

    logic             w_in_ready;
    logic             w_accept;
    logic             w_load;
    logic             w_last;
    logic             w_use_digit;
    t_cell_ctrl       w_ctrl;
    t_digits          w_digits;
    logic [31:0]      w_mag;
    logic [3:0]       w_len;
    logic [3:0]       w_ndig;
    logic [3:0]       w_k;
    logic [5:0]       w_col;
    logic [7:0]       w_code;
    logic [7:0]       w_dig_code;
    logic [9:0]       w_addr;

    osd_diw_chain u_chain (
        .i_clk    (i_clk),
        .i_ctrl   (w_ctrl),
        .i_bits   (r_bin[31:30]),
        .o_digits (w_digits)
    );

    assign w_accept = i_req.valid && w_in_ready;
    assign w_last   = (r_j == 4'(r_len - 4'd1));

    // Saturated magnitude and clamped field length of the incoming request.
    always_comb begin
        if (i_req.data.value[31]) begin
            if (i_req.data.value == 32'sh8000_0000) begin
                w_mag = 32'h7FFF_FFFF;
            end else begin
                w_mag = 32'(~i_req.data.value + 32'sd1);
            end
        end else begin
            w_mag = i_req.data.value;
        end
        if (i_req.data.field_len == 4'd0) begin
            w_len = 4'd1;
        end else if (i_req.data.field_len > 4'(MAX_DIGITS)) begin
            w_len = 4'(MAX_DIGITS);
        end else begin
            w_len = i_req.data.field_len;
        end
    end

    // Significant digit count and the number of digits the field shows.
    always_comb begin
        w_ndig = '0;
        for (int i = 0; i < NUM_CELLS; i++) begin
            if (w_digits[i] != 4'd0) begin
                w_ndig = 4'(i + 1);
            end
        end
        if (r_neg) begin
            w_k = (w_ndig < 4'(r_len - 4'd1)) ? w_ndig : 4'(r_len - 4'd1);
        end else if (w_ndig == 4'd0) begin
            w_k = 4'd1;
        end else begin
            w_k = (w_ndig < r_len) ? w_ndig : r_len;
        end
    end

    // Column and code of the write with index r_j.
    always_comb begin
        logic [5:0] s;
        logic [5:0] l;
        logic [5:0] j;
        logic [5:0] k;
        s = {1'b0, r_start};
        l = {2'b00, r_len};
        j = {2'b00, r_j};
        k = {2'b00, r_k};
        w_dig_code  = (w_digits[0] == 4'd0) ? CODE_ZERO : {4'b0000, w_digits[0]};
        w_use_digit = 1'b0;
        if (!r_blank) begin
            if (r_zero) begin
                w_col  = s + j;
                w_code = CODE_ZERO;
            end else if (!r_neg) begin
                w_col       = s + l - 6'd1 - j;
                w_code      = w_dig_code;
                w_use_digit = 1'b1;
            end else if (r_j == 4'd0) begin
                w_col  = s;
                w_code = CODE_MINUS;
            end else begin
                w_col       = s + l - j;
                w_code      = w_dig_code;
                w_use_digit = 1'b1;
            end
        end else begin
            if (r_j < r_k) begin
                w_col       = s + l - 6'd1 - j;
                w_code      = w_dig_code;
                w_use_digit = 1'b1;
            end else if (r_neg && w_last) begin
                w_col  = s;
                w_code = CODE_MINUS;
            end else begin
                w_col  = s + (j - k) + {5'b00000, r_neg};
                w_code = CODE_BLANK;
            end
        end
        w_addr = 10'(r_row) * 10'(COLUMNS_PER_ROW) + 10'(w_col);
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_accept) n_state = ST_CONV;
            end
            ST_CONV: begin
                if (r_cnt == CNT_W'(CONV_CYCLES - 1)) n_state = ST_PREP;
            end
            ST_PREP: begin
                n_state = ST_EMIT;
            end
            ST_EMIT: begin
                if (w_load && w_last) n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        w_in_ready   = 1'b0;
        w_load       = 1'b0;
        w_ctrl.clear = 1'b0;
        w_ctrl.conv  = 1'b0;
        w_ctrl.shift = 1'b0;
        case (r_state)
            ST_IDLE: begin
                w_in_ready   = 1'b1;
                w_ctrl.clear = i_req.valid;
            end
            ST_CONV: begin
                w_ctrl.conv = 1'b1;
            end
            ST_PREP: begin
            end
            ST_EMIT: begin
                w_load       = !r_out_valid || o_wr.ready;
                w_ctrl.shift = w_load && w_use_digit;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (o_wr.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_bin   <= w_mag;
            r_cnt   <= '0;
            r_blank <= i_req.data.req_type;
            r_neg   <= i_req.data.value[31];
            r_zero  <= (i_req.data.value == 32'sd0);
            r_row   <= i_req.data.row;
            r_start <= i_req.data.start_column;
            r_len   <= w_len;
        end else if (r_state == ST_CONV) begin
            r_bin <= {r_bin[29:0], 2'b00};
            r_cnt <= CNT_W'(r_cnt + 1'b1);
        end
        if (r_state == ST_PREP) begin
            r_k <= w_k;
            r_j <= '0;
        end else if (w_load) begin
            r_j <= 4'(r_j + 4'd1);
        end
        if (w_load) begin
            r_out.display_addr <= w_addr[8:0];
            r_out.char_code    <= w_code;
            r_out.last         <= w_last;
        end
    end

    assign i_req.ready = w_in_ready;
    assign o_wr.valid  = r_out_valid;
    assign o_wr.data   = r_out;

endmodule

FILE: sv/osd_diw_chk.sv
// Port-level checker for the decimal integer field writer, with its bind.
module osd_diw_chk
    import osd_diw_pkg::*;
(
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_valid,
    input logic i_in_ready,
    input logic i_out_valid,
    input logic i_out_ready,
    input t_wr  i_out_data
);

    // A write beat that is not taken stays offered.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> i_out_valid)
        else $error("write beat dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> $stable(i_out_data))
        else $error("write payload changed while stalled");

    // The block works on one request at a time.
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |=> !i_in_ready)
        else $error("request taken while a conversion is running");

    a_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_out_data.char_code == CODE_ZERO ||
                         i_out_data.char_code == CODE_MINUS ||
                         i_out_data.char_code == CODE_BLANK ||
                         (i_out_data.char_code >= 8'd1 && i_out_data.char_code <= 8'd9)))
        else $error("font code outside the digit, minus and blank set");

endmodule

bind osd_decimal_int_writer osd_diw_chk u_osd_diw_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_req.valid),
    .i_in_ready  (i_req.ready),
    .i_out_valid (o_wr.valid),
    .i_out_ready (o_wr.ready),
    .i_out_data  (o_wr.data)
);
